@@ rtl/core/spq_pkg.sv @@
// Shared constants and types for the sorted priority queue.
`default_nettype none
package spq_pkg;

  localparam int DEPTH    = 128;
  localparam int TAG_BITS = 16;

  localparam int KEY_W    = 32;
  localparam int TAG_W    = 16;
  localparam int OCC_W    = 8;
  // Stored tag width: the smaller of TAG_BITS and TAG_W, so here all 16 bits of the tag field are kept.
  localparam int STAG_W   = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
  localparam int CNT_W    = $clog2(DEPTH + 1);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic ins;
    logic pop;
  } cell_cmd_t;

endpackage : spq_pkg
`default_nettype wire

@@ rtl/core/spq_cell.sv @@
// One slot of the sorted chain: holds a key and tag, shifts up on insert, down on pop.
`default_nettype none
module spq_cell (
  input  wire logic                        clk,
  input  wire spq_pkg::cell_cmd_t          cmd,
  input  wire logic                        occupied,
  input  wire logic [spq_pkg::KEY_W-1:0]   new_key,
  input  wire logic [spq_pkg::STAG_W-1:0]  new_tag,
  input  wire logic                        gt_left,
  input  wire logic [spq_pkg::KEY_W-1:0]   left_key,
  input  wire logic [spq_pkg::STAG_W-1:0]  left_tag,
  input  wire logic [spq_pkg::KEY_W-1:0]   right_key,
  input  wire logic [spq_pkg::STAG_W-1:0]  right_tag,
  output logic                             gt,
  output logic [spq_pkg::KEY_W-1:0]        key_r,
  output logic [spq_pkg::STAG_W-1:0]       tag_r
);

  logic [spq_pkg::KEY_W-1:0]  key_nxt;
  logic [spq_pkg::STAG_W-1:0] tag_nxt;

  // Held entry sorts strictly after the incoming key.
  assign gt = occupied && (key_r > new_key);

  always_comb begin
    key_nxt = key_r;
    tag_nxt = tag_r;
    priority if (cmd.ins) begin
      priority if (gt_left) begin
        key_nxt = left_key;
        tag_nxt = left_tag;
      end else if (gt || !occupied) begin
        key_nxt = new_key;
        tag_nxt = new_tag;
      end else begin
        key_nxt = key_r;
        tag_nxt = tag_r;
      end
    end else if (cmd.pop) begin
      key_nxt = right_key;
      tag_nxt = right_tag;
    end else begin
      key_nxt = key_r;
      tag_nxt = tag_r;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    tag_r <= tag_nxt;
  end

endmodule : spq_cell
`default_nettype wire

@@ rtl/core/sorted_priority_queue_core.sv @@
// Top level of the sorted priority queue: a chain of key/tag cells plus fill count.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------------------------
//   in       | in_valid / in_ready  | in_operation, in_key, in_tag
//   out      | out_valid/out_ready  | out_ok, out_key, out_tag, out_occupancy
//
// One request per cycle: every cell compares and shifts in parallel in the cycle
// the request is accepted, so the rate is set only by the output register.
// The result is registered in the output register in the cycle after acceptance.
// Reset clears the fill count and output valid; cell contents stay undefined,
// since only slots below the fill count are ever read.
// A stalled output holds its result; a new request is taken in the cycle the
// held result leaves.
`default_nettype none
module sorted_priority_queue_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_operation,
  input  wire logic [spq_pkg::KEY_W-1:0]   in_key,
  input  wire logic [spq_pkg::TAG_W-1:0]   in_tag,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_ok,
  output logic [spq_pkg::KEY_W-1:0]        out_key,
  output logic [spq_pkg::TAG_W-1:0]        out_tag,
  output logic [spq_pkg::OCC_W-1:0]        out_occupancy
);

  localparam int N = spq_pkg::DEPTH;

  logic                          accept;
  logic                          full;
  logic                          empty;
  logic                          do_ins;
  logic                          do_pop;
  spq_pkg::cell_cmd_t            cmd;
  logic [spq_pkg::STAG_W-1:0]    new_tag;

  logic [spq_pkg::CNT_W-1:0]     count_r;
  logic [spq_pkg::CNT_W-1:0]     count_nxt;

  logic                          out_valid_r;
  logic                          out_ok_r;
  logic [spq_pkg::KEY_W-1:0]     out_key_r;
  logic [spq_pkg::TAG_W-1:0]     out_tag_r;
  logic [spq_pkg::OCC_W-1:0]     out_occ_r;

  logic [N-1:0]                  occ;
  logic [N-1:0]                  gt;
  logic [spq_pkg::KEY_W-1:0]     cell_key [N];
  logic [spq_pkg::STAG_W-1:0]    cell_tag [N];

  // Take a request whenever the output slot is free or being emptied.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign full   = (count_r == spq_pkg::CNT_W'(N));
  assign empty  = (count_r == '0);
  assign do_ins = accept && (in_operation == spq_pkg::OP_INSERT) && !full;
  assign do_pop = accept && (in_operation == spq_pkg::OP_POP) && !empty;

  assign cmd.ins = do_ins;
  assign cmd.pop = do_pop;

  // Drop tag bits above the stored width.
  assign new_tag = in_tag[spq_pkg::STAG_W-1:0];

  // Cell chain: slot 0 holds the smallest key.
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                       gt_l;
    logic [spq_pkg::KEY_W-1:0]  lk;
    logic [spq_pkg::STAG_W-1:0] lt;
    logic [spq_pkg::KEY_W-1:0]  rk;
    logic [spq_pkg::STAG_W-1:0] rt;

    assign occ[i] = (spq_pkg::CNT_W'(i) < count_r);

    if (i == 0) begin : g_first
      assign gt_l = 1'b0;
      assign lk   = in_key;
      assign lt   = new_tag;
    end else begin : g_mid
      assign gt_l = gt[i-1];
      assign lk   = cell_key[i-1];
      assign lt   = cell_tag[i-1];
    end

    if (i == N - 1) begin : g_last
      // Top slot is vacated by a pop; its contents no longer matter.
      assign rk = cell_key[i];
      assign rt = cell_tag[i];
    end else begin : g_inner
      assign rk = cell_key[i+1];
      assign rt = cell_tag[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occupied  (occ[i]),
      .new_key   (in_key),
      .new_tag   (new_tag),
      .gt_left   (gt_l),
      .left_key  (lk),
      .left_tag  (lt),
      .right_key (rk),
      .right_tag (rt),
      .gt        (gt[i]),
      .key_r     (cell_key[i]),
      .tag_r     (cell_tag[i])
    );
  end

  // Advance the fill count on a stored insert, drop it on a successful pop.
  always_comb begin
    count_nxt = count_r;
    priority if (do_ins) begin
      count_nxt = count_r + spq_pkg::CNT_W'(1);
    end else if (do_pop) begin
      count_nxt = count_r - spq_pkg::CNT_W'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: popped entry or zeros, plus the count after the request.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_ok_r  <= do_ins || do_pop;
      out_key_r <= do_pop ? cell_key[0] : '0;
      out_tag_r <= do_pop ? spq_pkg::TAG_W'(cell_tag[0]) : '0;
      out_occ_r <= spq_pkg::OCC_W'(count_nxt);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_ok        = out_ok_r;
  assign out_key       = out_key_r;
  assign out_tag       = out_tag_r;
  assign out_occupancy = out_occ_r;

endmodule : sorted_priority_queue_core
`default_nettype wire

@@ bench/tb_top.sv @@
// Testbench for sorted_priority_queue_core: directed and random requests against a predictor.
`timescale 1ns / 1ps

module tb_top;

  // Give up when nothing moves on either channel for this many cycles.
  localparam int STALL_LIMIT = 2000;
  // Hold the receiver off this long during the backpressure test.
  localparam int LONG_HOLD_OFF = 60;
  // Cycles to watch for stray results once every expected one has come.
  localparam int TAIL_CYCLES = 10;

  localparam logic [spq_pkg::TAG_W-1:0] STORED_TAG_MASK =
    {spq_pkg::TAG_W{1'b1}} >> (spq_pkg::TAG_W - spq_pkg::STAG_W);

  // One result as the block should report it.
  typedef struct packed {
    logic                      ok;
    logic [spq_pkg::KEY_W-1:0] key;
    logic [spq_pkg::TAG_W-1:0] tag;
    logic [spq_pkg::OCC_W-1:0] occupancy;
  } queue_result_t;

  logic                      clk           = 1'b0;
  logic                      rst_n         = 1'b0;
  logic                      in_valid      = 1'b0;
  logic                      in_operation  = spq_pkg::OP_INSERT;
  logic [spq_pkg::KEY_W-1:0] in_key        = '0;
  logic [spq_pkg::TAG_W-1:0] in_tag        = '0;
  logic                      out_ready     = 1'b0;
  logic                      in_ready;
  logic                      out_valid;
  logic                      out_ok;
  logic [spq_pkg::KEY_W-1:0] out_key;
  logic [spq_pkg::TAG_W-1:0] out_tag;
  logic [spq_pkg::OCC_W-1:0] out_occupancy;

  // Predicted queue contents, slot 0 holds the smallest key.
  logic [spq_pkg::KEY_W-1:0] held_keys[$];
  logic [spq_pkg::TAG_W-1:0] held_tags[$];
  // Results predicted at acceptance, oldest first.
  queue_result_t    awaited_results[$];

  int  tx_idle_pct     = 0;
  int  rx_idle_pct     = 0;
  int  hold_off_req    = 0;
  int  quiet_cycles    = 0;
  bit  failed          = 1'b0;

  sorted_priority_queue_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_key        (in_key),
    .in_tag        (in_tag),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_ok        (out_ok),
    .out_key       (out_key),
    .out_tag       (out_tag),
    .out_occupancy (out_occupancy)
  );

  always #4 clk = ~clk;

  // Apply one accepted request to the predicted queue and return its result.
  // Insert goes behind every held key that is smaller or equal, so equal
  // keys leave in arrival order; a full queue drops the entry. Pop takes
  // slot 0 or reports empty. Key and tag are zero on every insert result.
  function automatic queue_result_t apply_queue_op(input logic op,
                                                   input logic [spq_pkg::KEY_W-1:0] key,
                                                   input logic [spq_pkg::TAG_W-1:0] tag);
    queue_result_t r;
    int pos;
    r = '0;
    if (op == spq_pkg::OP_INSERT) begin
      if (held_keys.size() < spq_pkg::DEPTH) begin
        pos = held_keys.size();
        while (pos > 0 && held_keys[pos-1] > key) pos--;
        held_keys.insert(pos, key);
        held_tags.insert(pos, tag & STORED_TAG_MASK);
        r.ok = 1'b1;
      end
    end else begin
      if (held_keys.size() > 0) begin
        r.ok  = 1'b1;
        r.key = held_keys.pop_front();
        r.tag = held_tags.pop_front();
      end
    end
    r.occupancy = spq_pkg::OCC_W'(held_keys.size());
    return r;
  endfunction

  // Mix of key classes: a narrow range makes plenty of equal keys, the
  // extremes hit the compare at both ends, the rest spans all 32 bits.
  function automatic logic [spq_pkg::KEY_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(99);
    if (sel < 25) return spq_pkg::KEY_W'($urandom_range(15));
    if (sel < 35) begin
      case ($urandom_range(3))
        0: return '0;
        1: return spq_pkg::KEY_W'(1);
        2: return {spq_pkg::KEY_W{1'b1}} - spq_pkg::KEY_W'(1);
        default: return {spq_pkg::KEY_W{1'b1}};
      endcase
    end
    return spq_pkg::KEY_W'($urandom);
  endfunction

  function automatic logic [spq_pkg::TAG_W-1:0] pick_tag();
    if ($urandom_range(19) == 0) return $urandom_range(1) ? '1 : '0;
    return spq_pkg::TAG_W'($urandom_range(65535));
  endfunction

  // Offer one request, hold it until accepted, then record its prediction.
  // Drop valid for a random number of cycles first when the sender idles.
  task automatic send_request(input logic op, input logic [spq_pkg::KEY_W-1:0] key,
                              input logic [spq_pkg::TAG_W-1:0] tag);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_key       <= key;
    in_tag       <= tag;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    awaited_results.push_back(apply_queue_op(op, key, tag));
  endtask

  // Stop offering and wait until every predicted result has been checked.
  task automatic wait_queue_drained();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // Extremes of key and tag, pop on empty, equal keys in arrival order,
  // and an equal-to-smallest insert; then pop everything and one past empty.
  task automatic test_directed_cases();
    send_request(spq_pkg::OP_POP, '1, '1);
    send_request(spq_pkg::OP_INSERT, '1, '1);
    send_request(spq_pkg::OP_INSERT, '0, '0);
    send_request(spq_pkg::OP_INSERT, 32'h8000_0000, 16'h8000);
    for (int i = 1; i <= 4; i++) begin
      send_request(spq_pkg::OP_INSERT, 32'h0000_1234, spq_pkg::TAG_W'(i));
    end
    send_request(spq_pkg::OP_INSERT, 32'hAAAA_AAAA, 16'h5555);
    send_request(spq_pkg::OP_INSERT, 32'h5555_5555, 16'hAAAA);
    send_request(spq_pkg::OP_INSERT, '0, '1);
    for (int i = 0; i < 11; i++) send_request(spq_pkg::OP_POP, pick_key(), pick_tag());
    wait_queue_drained();
  endtask

  // Random requests; insert_pct steers the fill level toward full or empty.
  task automatic test_random_traffic(input int count, input int insert_pct);
    logic op;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(99) < insert_pct) ? spq_pkg::OP_INSERT : spq_pkg::OP_POP;
      send_request(op, pick_key(), pick_tag());
    end
    wait_queue_drained();
  endtask

  // Hold the receiver off for a long stretch while requests keep coming,
  // so the output register fills and the input stalls.
  task automatic test_output_backpressure();
    logic op;
    hold_off_req = LONG_HOLD_OFF;
    for (int i = 0; i < 20; i++) begin
      op = ($urandom_range(99) < 60) ? spq_pkg::OP_INSERT : spq_pkg::OP_POP;
      send_request(op, pick_key(), pick_tag());
    end
    wait_queue_drained();
  endtask

  // Receiver: random ready, or a counted hold-off when one is requested.
  always @(posedge clk) begin : receiver
    static int hold_left = 0;
    if (hold_off_req > 0) begin
      hold_left    = hold_off_req;
      hold_off_req = 0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin : result_check
    queue_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $error("result with no request outstanding: ok=%0d key=%h tag=%h occupancy=%0d",
               out_ok, out_key, out_tag, out_occupancy);
        failed = 1'b1;
      end else begin
        want = awaited_results.pop_front();
        if (out_ok !== want.ok) begin
          $error("out_ok: expected %0d, actual %0d", want.ok, out_ok);
          failed = 1'b1;
        end
        if (out_key !== want.key) begin
          $error("out_key: expected %h, actual %h", want.key, out_key);
          failed = 1'b1;
        end
        if (out_tag !== want.tag) begin
          $error("out_tag: expected %h, actual %h", want.tag, out_tag);
          failed = 1'b1;
        end
        if (out_occupancy !== want.occupancy) begin
          $error("out_occupancy: expected %0d, actual %0d", want.occupancy, out_occupancy);
          failed = 1'b1;
        end
      end
    end
  end

  // End the run when neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Sender idles often, receiver idles more.
    tx_idle_pct = 35;
    rx_idle_pct = 52;
    test_directed_cases();
    test_random_traffic(250, 90);  // fill up and run into rejects
    test_random_traffic(250, 15);  // drain down and pop on empty
    test_output_backpressure();

    // Swap the idle rates.
    tx_idle_pct = 52;
    rx_idle_pct = 35;
    test_random_traffic(300, 55);
    test_random_traffic(200, 80);

    // Full rate on both sides.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_traffic(200, 50);
    test_random_traffic(200, 20);

    // Watch for stray results after the last one is in.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (!failed && awaited_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sorted_priority_queue_core.f @@
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue_core.sv
bench/tb_top.sv
